FILE: src/sam_rfp_pkg.sv
// ----------------------------------------------------------------------------
// sam_rfp_pkg
// Shared types and character codes for the SAM record field parser.
// ----------------------------------------------------------------------------
package sam_rfp_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_END    = 2'd2,
    KIND_HEADER = 2'd3
  } kind_t;

  // Number conversion modes for the FLAG field
  typedef enum logic [1:0] {
    RADIX_DEC  = 2'd0,
    RADIX_OCT  = 2'd1,
    RADIX_HEX  = 2'd2,
    RADIX_NONE = 2'd3
  } radix_t;

  // Field numbers with special handling
  localparam logic [3:0] FIELD_FLAG   = 4'd1;
  localparam logic [3:0] FIELD_POS    = 4'd3;
  localparam logic [3:0] FIELD_MAPQ   = 4'd4;
  localparam logic [3:0] FIELD_PNEXT  = 4'd7;
  localparam logic [3:0] FIELD_TLEN   = 4'd8;
  localparam logic [3:0] FIELD_QUAL   = 4'd10;
  localparam logic [3:0] FIELD_EXTRAS = 4'd11;

  // Character codes
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_AT      = 8'h40;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ONE     = 8'h31;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  // Offsets that turn a hex letter into its digit value
  localparam logic [7:0] HEX_LOWER_OFFSET = 8'd87;
  localparam logic [7:0] HEX_UPPER_OFFSET = 8'd55;

  localparam logic [1:0] DIGIT_POS_MAX = 2'd3;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  field_index;
    logic [7:0]  text_byte;
    logic [31:0] number_value;
    logic        last;
  } result_t;

  // Fields holding a converted number
  function automatic logic is_numeric(input logic [3:0] f);
    return (f == FIELD_FLAG) || (f == FIELD_POS) || (f == FIELD_MAPQ) ||
           (f == FIELD_PNEXT) || (f == FIELD_TLEN);
  endfunction

endpackage

FILE: src/sam_record_field_parser.sv
// ----------------------------------------------------------------------------
// sam_record_field_parser
// Splits a SAM text stream into fields, passes text bytes on and converts
// the numeric fields (FLAG, POS, MAPQ, PNEXT, TLEN) to values.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Handshake
//  --------  ----------------------------------------  ----------------------
//  input     data_byte                                 data_valid / data_stall
//  output    kind, field_index, text_byte,             result_valid /
//            number_value, last                        result_stall
//
//  One byte is taken per cycle while data_stall is low; its results appear
//  in the output register on the next cycle. A byte that causes two results
//  (a newline that closes a numeric field: the number, then the record end)
//  holds the input while the second result drains from the pending slot.
//  Input stalls only while a second result is pending or the output register
//  is full and stalled. Synchronous active-high reset returns to line start.
//
module sam_record_field_parser
  import sam_rfp_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_stall,
  input  logic [7:0]         data_byte,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         kind,
  output logic [3:0]         field_index,
  output logic [7:0]         text_byte,
  output logic signed [31:0] number_value,
  output logic               last
);

  localparam int NW = NUMBER_WIDTH;

  // Parser state
  logic [3:0]    field_number, field_number_next;
  logic [NW-1:0] accumulator, accumulator_next;
  radix_t        radix_mode, radix_mode_next;
  logic [1:0]    digit_position, digit_position_next;
  logic          negate_flag, negate_flag_next;
  logic          line_start, line_start_next;
  logic          header_line, header_line_next;

  // Output register and pending second result
  result_t out_res;
  result_t pend_res;
  logic    pend_valid;

  // Per-byte results
  result_t res0, res1;
  logic [1:0] res_count;

  logic accept;
  logic take;

  // Conversion helpers
  logic [NW-1:0] dec_digit;
  logic [NW-1:0] hex_digit;
  logic [NW-1:0] acc_x8;
  logic [NW-1:0] acc_x10;
  logic [NW-1:0] acc_x16;
  logic [NW-1:0] field_val;
  logic [63:0]   field_val_wide;
  logic [31:0]   field_val32;
  logic          tab;

  assign take       = result_valid && !result_stall;
  assign data_stall = pend_valid || (result_valid && result_stall);
  assign accept     = data_valid && !data_stall;

  // Digit values and scaled accumulator
  assign dec_digit = NW'(data_byte) - NW'(CHAR_ZERO);
  always_comb begin
    if (data_byte >= CHAR_LOWER_A) begin
      hex_digit = NW'(data_byte) - NW'(HEX_LOWER_OFFSET);
    end else if (data_byte >= CHAR_UPPER_A) begin
      hex_digit = NW'(data_byte) - NW'(HEX_UPPER_OFFSET);
    end else begin
      hex_digit = dec_digit;
    end
  end
  assign acc_x8  = accumulator << 3;
  assign acc_x10 = (accumulator << 3) + (accumulator << 1);
  assign acc_x16 = accumulator << 4;

  // Value of the open numeric field, zero-extended to the 32-bit port
  assign field_val      = negate_flag ? (NW'(0) - accumulator) : accumulator;
  assign field_val_wide = 64'(field_val);
  assign field_val32    = field_val_wide[31:0];

  assign tab = (data_byte == CHAR_TAB);

  // Next state and results for the incoming byte
  always_comb begin
    field_number_next   = field_number;
    accumulator_next    = accumulator;
    radix_mode_next     = radix_mode;
    digit_position_next = digit_position;
    negate_flag_next    = negate_flag;
    line_start_next     = 1'b0;
    header_line_next    = header_line;
    res0                = '0;
    res1                = '0;
    res_count           = 2'd0;

    if (data_byte == CHAR_NEWLINE) begin
      // End of line: flush open number, report end or header
      if (header_line) begin
        res0.kind = KIND_HEADER;
        res_count = 2'd1;
      end else if (is_numeric(field_number)) begin
        res0.kind         = KIND_NUMBER;
        res0.field_index  = field_number;
        res0.number_value = field_val32;
        res1.kind         = KIND_END;
        res1.field_index  = field_number;
        res_count         = 2'd2;
      end else begin
        res0.kind        = KIND_END;
        res0.field_index = field_number;
        res_count        = 2'd1;
      end
      field_number_next   = 4'd0;
      accumulator_next    = '0;
      radix_mode_next     = RADIX_DEC;
      digit_position_next = 2'd0;
      negate_flag_next    = 1'b0;
      header_line_next    = 1'b0;
      line_start_next     = 1'b1;
    end else if (header_line) begin
      // Drop header bytes
    end else if (line_start && data_byte == CHAR_AT) begin
      header_line_next = 1'b1;
    end else if (tab && field_number < FIELD_QUAL) begin
      // Close field, emit its number if numeric
      if (is_numeric(field_number)) begin
        res0.kind         = KIND_NUMBER;
        res0.field_index  = field_number;
        res0.number_value = field_val32;
        res_count         = 2'd1;
      end
      field_number_next   = field_number + 4'd1;
      accumulator_next    = '0;
      radix_mode_next     = RADIX_DEC;
      digit_position_next = 2'd0;
      negate_flag_next    = 1'b0;
    end else if (tab && field_number == FIELD_QUAL) begin
      // Enter extras tail, leading tab is its first byte
      field_number_next   = FIELD_EXTRAS;
      accumulator_next    = '0;
      radix_mode_next     = RADIX_DEC;
      digit_position_next = 2'd0;
      negate_flag_next    = 1'b0;
      res0.kind           = KIND_TEXT;
      res0.field_index    = FIELD_EXTRAS;
      res0.text_byte      = data_byte;
      res_count           = 2'd1;
    end else if (is_numeric(field_number)) begin
      // Accumulate digit
      if (field_number == FIELD_FLAG) begin
        if (digit_position == 2'd0) begin
          if (data_byte == CHAR_ZERO) begin
            radix_mode_next  = RADIX_OCT;
            accumulator_next = '0;
          end else if (data_byte >= CHAR_ONE && data_byte <= CHAR_NINE) begin
            radix_mode_next  = RADIX_DEC;
            accumulator_next = dec_digit;
          end else begin
            radix_mode_next  = RADIX_NONE;
            accumulator_next = '0;
          end
        end else if (radix_mode == RADIX_NONE) begin
          // Not a number: ignore rest of field
        end else if (digit_position == 2'd1 && radix_mode == RADIX_OCT &&
                     (data_byte == CHAR_LOWER_X || data_byte == CHAR_UPPER_X)) begin
          radix_mode_next  = RADIX_HEX;
          accumulator_next = '0;
        end else if (radix_mode == RADIX_HEX) begin
          accumulator_next = acc_x16 + hex_digit;
        end else if (radix_mode == RADIX_OCT) begin
          accumulator_next = acc_x8 + dec_digit;
        end else begin
          accumulator_next = acc_x10 + dec_digit;
        end
      end else if (field_number == FIELD_TLEN && digit_position == 2'd0 &&
                   data_byte == CHAR_MINUS) begin
        negate_flag_next = 1'b1;
      end else begin
        accumulator_next = acc_x10 + dec_digit;
      end
      if (digit_position < DIGIT_POS_MAX) begin
        digit_position_next = digit_position + 2'd1;
      end
    end else begin
      // Pass text byte on
      if (field_number > FIELD_EXTRAS) begin
        field_number_next = FIELD_EXTRAS;
      end
      res0.kind        = KIND_TEXT;
      res0.field_index = (field_number > FIELD_EXTRAS) ? FIELD_EXTRAS : field_number;
      res0.text_byte   = data_byte;
      res_count        = 2'd1;
    end

    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      field_number   <= 4'd0;
      accumulator    <= '0;
      radix_mode     <= RADIX_DEC;
      digit_position <= 2'd0;
      negate_flag    <= 1'b0;
      line_start     <= 1'b1;
      header_line    <= 1'b0;
    end else if (accept) begin
      field_number   <= field_number_next;
      accumulator    <= accumulator_next;
      radix_mode     <= radix_mode_next;
      digit_position <= digit_position_next;
      negate_flag    <= negate_flag_next;
      line_start     <= line_start_next;
      header_line    <= header_line_next;
    end
  end

  // Load results, or drain the pending one into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else if (accept) begin
      result_valid <= (res_count != 2'd0);
      pend_valid   <= (res_count == 2'd2);
    end else if (take) begin
      result_valid <= pend_valid;
      pend_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res  <= res0;
      pend_res <= res1;
    end else if (take) begin
      out_res <= pend_res;
    end
  end

  assign kind         = out_res.kind;
  assign field_index  = out_res.field_index;
  assign text_byte    = out_res.text_byte;
  assign number_value = out_res.number_value;
  assign last         = out_res.last;

endmodule

FILE: tb/sam_field_checker.sv
// ----------------------------------------------------------------------------
// sam_field_checker
// Watches both channels of the SAM record field parser, splits every accepted
// byte with its own field tracker and compares each result item, field by
// field, with the oldest expected one. Failures are counted for the top.
// ----------------------------------------------------------------------------
module sam_field_checker
  import sam_rfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  input  logic               data_stall,
  input  logic [7:0]         data_byte,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic [1:0]         kind,
  input  logic [3:0]         field_index,
  input  logic [7:0]         text_byte,
  input  logic signed [31:0] number_value,
  input  logic               last,
  output int                 fail_count,
  output int                 pending_count,
  output int                 byte_count,
  output int                 result_count,
  output int                 number_count,
  output int                 header_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  // Field tracker state
  logic [3:0]  cur_field;
  logic [31:0] acc;
  radix_t      radix;
  logic [1:0]  digit_pos;
  logic        negate;
  logic        at_line_start;
  logic        in_header;

  result_t field_results_q[$];

  function automatic logic numeric_field(input logic [3:0] f);
    case (f)
      FIELD_FLAG, FIELD_POS, FIELD_MAPQ, FIELD_PNEXT, FIELD_TLEN: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [3:0] f,
                                          input logic [7:0] t, input logic [31:0] v);
    result_t r;
    r.kind         = k;
    r.field_index  = f;
    r.text_byte    = t;
    r.number_value = v;
    r.last         = 1'b0;
    return r;
  endfunction

  task automatic clear_number();
    acc       = '0;
    radix     = RADIX_DEC;
    digit_pos = '0;
    negate    = 1'b0;
  endtask

  // Update the FLAG conversion with one byte
  task automatic take_flag(input logic [7:0] c);
    logic [31:0] code;
    logic [31:0] digit;
    code = {24'd0, c};
    if (digit_pos == 2'd0) begin
      if (c == CHAR_ZERO) begin
        radix = RADIX_OCT;
        acc   = '0;
      end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
        radix = RADIX_DEC;
        acc   = code - 32'(CHAR_ZERO);
      end else begin
        radix = RADIX_NONE;
        acc   = '0;
      end
    end else if (radix == RADIX_NONE) begin
      // rest of a non-number is ignored
    end else if (digit_pos == 2'd1 && radix == RADIX_OCT &&
                 (c == CHAR_LOWER_X || c == CHAR_UPPER_X)) begin
      radix = RADIX_HEX;
      acc   = '0;
    end else if (radix == RADIX_HEX) begin
      if (c >= CHAR_LOWER_A)
        digit = code - 32'(CHAR_LOWER_A) + 32'd10;
      else if (c >= CHAR_UPPER_A)
        digit = code - 32'(CHAR_UPPER_A) + 32'd10;
      else
        digit = code - 32'(CHAR_ZERO);
      acc = (acc << 4) + digit;
    end else begin
      acc = acc * ((radix == RADIX_OCT) ? 32'd8 : 32'd10) + (code - 32'(CHAR_ZERO));
    end
  endtask

  // Split one accepted byte and queue the result items it causes
  task automatic split_byte(input logic [7:0] c);
    result_t     got[$];
    logic        first;
    logic [31:0] value;
    first         = at_line_start;
    at_line_start = 1'b0;
    value         = negate ? -acc : acc;

    if (c == CHAR_NEWLINE) begin
      if (in_header) begin
        got.push_back(make_result(KIND_HEADER, 4'd0, 8'd0, 32'd0));
      end else begin
        if (numeric_field(cur_field))
          got.push_back(make_result(KIND_NUMBER, cur_field, 8'd0, value));
        got.push_back(make_result(KIND_END, cur_field, 8'd0, 32'd0));
      end
      cur_field = '0;
      clear_number();
      in_header     = 1'b0;
      at_line_start = 1'b1;
    end else if (in_header) begin
      // header bytes are swallowed
    end else if (first && c == CHAR_AT) begin
      in_header = 1'b1;
    end else if (c == CHAR_TAB && cur_field < FIELD_QUAL) begin
      if (numeric_field(cur_field))
        got.push_back(make_result(KIND_NUMBER, cur_field, 8'd0, value));
      cur_field = cur_field + 4'd1;
      clear_number();
    end else if (c == CHAR_TAB && cur_field == FIELD_QUAL) begin
      // the tab closing QUAL opens the extras tail and is part of it
      cur_field = FIELD_EXTRAS;
      clear_number();
      got.push_back(make_result(KIND_TEXT, FIELD_EXTRAS, c, 32'd0));
    end else if (numeric_field(cur_field)) begin
      if (cur_field == FIELD_FLAG)
        take_flag(c);
      else if (cur_field == FIELD_TLEN && digit_pos == 2'd0 && c == CHAR_MINUS)
        negate = 1'b1;
      else
        acc = acc * 32'd10 + ({24'd0, c} - 32'(CHAR_ZERO));
      if (digit_pos != DIGIT_POS_MAX)
        digit_pos = digit_pos + 2'd1;
    end else begin
      got.push_back(make_result(KIND_TEXT, cur_field, c, 32'd0));
    end

    if (got.size() > 0)
      got[got.size() - 1].last = 1'b1;
    foreach (got[i])
      field_results_q.push_back(got[i]);
  endtask

  // Compare one accepted result item with the oldest expectation
  task automatic check_result();
    result_t want;
    if (field_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("[%0t] unexpected result: kind %0d field %0d text %02h number %0d last %0b",
                 $realtime, kind, field_index, text_byte, number_value, last);
      return;
    end
    want = field_results_q.pop_front();
    result_count++;
    if (kind == KIND_NUMBER) number_count++;
    if (kind == KIND_HEADER) header_count++;
    if (kind !== want.kind || field_index !== want.field_index ||
        text_byte !== want.text_byte || number_value !== want.number_value ||
        last !== want.last) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display({"[%0t] mismatch: expected kind %0d field %0d text %02h number %0d ",
                  "last %0b, got kind %0d field %0d text %02h number %0d last %0b"},
                 $realtime, want.kind, want.field_index, want.text_byte,
                 $signed(want.number_value), want.last,
                 kind, field_index, text_byte, number_value, last);
    end
  endtask

  // Check results before queueing new ones; a byte's results show next cycle
  always @(posedge clk) begin
    if (rst) begin
      cur_field     = '0;
      clear_number();
      at_line_start = 1'b1;
      in_header     = 1'b0;
      field_results_q.delete();
      fail_count    = 0;
      byte_count    = 0;
      result_count  = 0;
      number_count  = 0;
      header_count  = 0;
    end else begin
      if (result_valid && !result_stall)
        check_result();
      if (data_valid && !data_stall) begin
        byte_count++;
        split_byte(data_byte);
      end
    end
    pending_count = field_results_q.size();
  end

endmodule

FILE: tb/tb_sam_record_field_parser.sv
// ----------------------------------------------------------------------------
// tb_sam_record_field_parser
// Feeds SAM text to the record field parser: a short directed set of lines,
// then random records, header lines and noise under three idling patterns
// and one long output hold-off. A checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb_sam_record_field_parser;
  import sam_rfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BYTES   = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int DRAIN_LIMIT   = 5000;
  // about 850 bytes, at most two results each, long random stalls: far below this
  localparam int RUN_LIMIT_NS  = 2_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               data_valid = 1'b0;
  logic               data_stall;
  logic [7:0]         data_byte = 8'd0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [1:0]         kind;
  logic [3:0]         field_index;
  logic [7:0]         text_byte;
  logic signed [31:0] number_value;
  logic               last;

  int fail_count, pending_count, byte_count, result_count, number_count, header_count;

  int send_idle_pct = 29;
  int recv_idle_pct = 86;
  int hold_left     = 0;

  logic [7:0] text_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sam_record_field_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .field_index  (field_index),
    .text_byte    (text_byte),
    .number_value (number_value),
    .last         (last)
  );

  sam_field_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .kind          (kind),
    .field_index   (field_index),
    .text_byte     (text_byte),
    .number_value  (number_value),
    .last          (last),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .byte_count    (byte_count),
    .result_count  (result_count),
    .number_count  (number_count),
    .header_count  (header_count)
  );

  // Stall the output at random, or hold it off for a counted stretch
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one item, idling at random before it, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      data_valid <= 1'b0;
      @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    @(posedge clk);
    while (data_stall)
      @(posedge clk);
  endtask

  task automatic send_text();
    while (text_q.size() > 0)
      send_byte(text_q.pop_front());
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++)
      text_q.push_back(s[i]);
  endtask

  // Append n characters drawn from a set
  task automatic add_from(input string set, input int n);
    for (int i = 0; i < n; i++)
      text_q.push_back(set[$urandom_range(set.len() - 1)]);
  endtask

  // Append n bytes of any value except the tab and newline separators
  task automatic add_text(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do
        b = 8'($urandom_range(255));
      while (b == CHAR_TAB || b == CHAR_NEWLINE);
      text_q.push_back(b);
    end
  endtask

  // Append the content of one field, well formed most of the time
  task automatic add_field(input logic [3:0] f);
    int pick;
    pick = $urandom_range(9);
    case (f)
      FIELD_FLAG: begin
        case (pick % 6)
          0: ;
          1: begin add_from("123456789", 1); add_from("0123456789", $urandom_range(10)); end
          2: begin add_str("0"); add_from("01234567", $urandom_range(12)); end
          3: begin
            add_str("0");
            add_from("xX", 1);
            add_from("0123456789abcdefABCDEF", $urandom_range(10));
          end
          default: add_text($urandom_range(1, 4));
        endcase
      end
      FIELD_POS, FIELD_MAPQ, FIELD_PNEXT: begin
        if (pick < 8) add_from("0123456789", $urandom_range(12));
        else          add_text($urandom_range(1, 4));
      end
      FIELD_TLEN: begin
        if (pick < 8) begin
          if (pick < 4) add_str("-");
          add_from("0123456789", $urandom_range(12));
        end else begin
          add_from("0123456789-", $urandom_range(1, 5));
        end
      end
      default: add_text($urandom_range(5));
    endcase
  endtask

  // Append one line: a record, a cut-off record, a header line or noise
  task automatic add_line();
    int pick;
    int top_field;
    pick = $urandom_range(99);
    if (pick < 8) begin
      add_str("@");
      add_text($urandom_range(6));
    end else if (pick < 16) begin
      for (int i = $urandom_range(1, 15); i > 0; i--)
        text_q.push_back(8'($urandom_range(255)));
    end else begin
      top_field = (pick < 30) ? $urandom_range(10) : FIELD_QUAL;
      for (int f = 0; f <= top_field; f++) begin
        if (f > 0) text_q.push_back(CHAR_TAB);
        add_field(f[3:0]);
      end
      if (top_field == FIELD_QUAL && $urandom_range(1) == 1) begin
        for (int t = $urandom_range(1, 3); t > 0; t--) begin
          text_q.push_back(CHAR_TAB);
          add_text($urandom_range(1, 6));
        end
      end
    end
    text_q.push_back(CHAR_NEWLINE);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (text_q.size() < PHASE_BYTES)
      add_line();
    send_text();
  endtask

  // Stimulus and verdict
  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty line, header, hex FLAG ended by newline, then a record
    // with octal FLAG, negative TLEN, extras tail and extreme byte values
    add_str("\n@\n\t0xaF\n");
    text_q.push_back(8'hFF);
    add_str("\t07\t\t\t\t\t\t\t-9\t\t\t");
    text_q.push_back(8'h00);
    add_str("\r\n");
    send_text();

    random_phase(29, 86);
    random_phase(86, 29);

    // No idling, but one long output hold-off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk);
    data_valid <= 1'b0;
    hold_left = HOLD_CYCLES;
    random_phase(0, 0);

    @(negedge clk);
    data_valid <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_count != 0; w++)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_count != 0)
      $display("%0d expected results never arrived", pending_count);
    $display("Sent %0d bytes of SAM text and checked %0d results",
             byte_count, result_count);
    $display("(%0d numbers, %0d header lines).", number_count, header_count);
    $display("Covered directed lines, three idling patterns and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d results still expected", pending_count);
    $display("TEST FAILED");
    $finish;
  end

endmodule
